// File: rtl/core/dqc_pkg.sv
// ----------------------------------------------------------------------------
// dqc_pkg
// Shared types for the double-ended queue: operation codes and the control
// bundle that the top level drives into every storage cell.
// ----------------------------------------------------------------------------
`default_nettype none

package dqc_pkg;

    localparam int FUNC_W = 4;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 4'd0,
        FN_PUSH_BACK  = 4'd1,
        FN_POP_FRONT  = 4'd2,
        FN_POP_BACK   = 4'd3,
        FN_CUR_FRONT  = 4'd4,
        FN_CUR_BACK   = 4'd5,
        FN_CUR_NEXT   = 4'd6,
        FN_CUR_PREV   = 4'd7,
        FN_CLEAR      = 4'd8
    } t_func;

    // shr: every cell takes its left neighbor (cell 0 takes the pushed word)
    // shl: every cell takes its right neighbor
    // wr : the cell at the write position takes the pushed word
    // rd : the cell at the read position drives its word onto the read bus
    typedef struct packed {
        logic shr;
        logic shl;
        logic wr;
        logic rd;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: rtl/core/dqc_cell.sv
// ----------------------------------------------------------------------------
// dqc_cell
// One queue position. Holds one word, shifts toward either neighbor, takes a
// pushed word at its position and drives its word when selected for a read.
// ----------------------------------------------------------------------------
`default_nettype none

module dqc_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IW         = 4,
    parameter int IDX        = 0
) (
    input  wire                    i_clk,
    input  dqc_pkg::t_cell_ctl     i_ctl,
    input  wire [IW-1:0]           i_wr_pos,
    input  wire [IW-1:0]           i_rd_pos,
    input  wire [DATA_WIDTH-1:0]   i_data_in,
    input  wire [DATA_WIDTH-1:0]   i_prev,
    input  wire [DATA_WIDTH-1:0]   i_next,
    output logic [DATA_WIDTH-1:0]  o_data,
    output logic [DATA_WIDTH-1:0]  o_tap
);
    import dqc_pkg::*;

    localparam logic [IW-1:0] MY_POS = IW'(IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        priority if (i_ctl.shr) begin
            n_data = i_prev;
        end else if (i_ctl.shl) begin
            n_data = i_next;
        end else if (i_ctl.wr && (i_wr_pos == MY_POS)) begin
            n_data = i_data_in;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = (i_ctl.rd && (i_rd_pos == MY_POS)) ? r_data : '0;

endmodule

`default_nettype wire

// File: rtl/core/deque_with_cursor.sv
// ----------------------------------------------------------------------------
// deque_with_cursor
// Bounded double-ended queue with a walking cursor, built as a row of cells.
//
// Input channel (i_in_valid / o_in_ready) carries one operation per beat:
// push front/back, pop front/back, cursor to front/back, cursor next/prev
// (reading the word under the cursor first) or clear. Output channel
// (o_out_valid / i_out_ready) returns one result beat per operation with the
// data word, its valid flag, entry count, empty, full and push-rejected.
// Entries sit in order in the cell row, front at cell 0; a push or pop at
// the front shifts the whole row by one cell in the same clock.
// The result appears in the cycle after accept. One operation per cycle is
// taken while the result register is empty or being drained; the read word
// comes from a one-hot select over the row into that register.
// When the receiver stalls, the result is held and the input stalls too.
// Reset empties the queue and invalidates the cursor; stored words are not
// cleared and are never read before they are written.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_cursor #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire [dqc_pkg::FUNC_W-1:0]    i_func,
    input  wire [DATA_WIDTH-1:0]         i_data_in,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [DATA_WIDTH-1:0]        o_data_out,
    output logic                         o_data_valid,
    output logic [$clog2(DEPTH+1)-1:0]   o_entry_count,
    output logic                         o_is_empty,
    output logic                         o_is_full,
    output logic                         o_rejected
);
    import dqc_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_cur, n_cur;
    logic          r_live, n_live;

    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_data_out;
    logic                  r_data_valid;
    logic [CW-1:0]         r_count;
    logic                  r_empty;
    logic                  r_full;
    logic                  r_rej;

    t_cell_ctl     w_ctl;
    logic [IW-1:0] w_wr_pos;
    logic [IW-1:0] w_rd_pos;
    logic          w_dvalid;
    logic          w_rej;
    logic          w_accept;
    logic          w_full;
    logic          w_empty;
    logic [IW-1:0] w_back;
    logic [DATA_WIDTH-1:0] w_rd_data;

    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DATA_WIDTH-1:0] w_tap  [DEPTH];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_cnt == CW'(DEPTH));
    assign w_empty    = (r_cnt == '0);
    assign w_back     = IW'(r_cnt - CW'(1));

    // ---- cell row ----
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_prev;
            logic [DATA_WIDTH-1:0] w_next;
            if (gi == 0) begin : g_first
                assign w_prev = i_data_in;
            end else begin : g_mid_l
                assign w_prev = w_data[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign w_next = w_data[gi];
            end else begin : g_mid_r
                assign w_next = w_data[gi+1];
            end
            dqc_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .IW         (IW),
                .IDX        (gi)
            ) u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_wr_pos  (w_wr_pos),
                .i_rd_pos  (w_rd_pos),
                .i_data_in (i_data_in),
                .i_prev    (w_prev),
                .i_next    (w_next),
                .o_data    (w_data[gi]),
                .o_tap     (w_tap[gi])
            );
        end
    endgenerate

    // only the selected cell drives a nonzero tap
    always_comb begin
        w_rd_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd_data = w_rd_data | w_tap[k];
        end
    end

    // ---- operation decode ----
    always_comb begin
        n_cnt    = r_cnt;
        n_cur    = r_cur;
        n_live   = r_live;
        w_ctl    = '0;
        w_wr_pos = '0;
        w_rd_pos = '0;
        w_dvalid = 1'b0;
        w_rej    = 1'b0;
        unique case (i_func)
            FN_PUSH_FRONT: begin
                if (w_full) begin
                    w_rej = 1'b1;
                end else begin
                    w_ctl.shr = w_accept;
                    n_cnt     = r_cnt + CW'(1);
                    if (!w_empty) begin
                        // old front now sits in cell 1
                        n_cur  = IW'(1);
                        n_live = 1'b1;
                    end
                end
            end
            FN_PUSH_BACK: begin
                if (w_full) begin
                    w_rej = 1'b1;
                end else begin
                    w_ctl.wr = w_accept;
                    w_wr_pos = IW'(r_cnt);
                    n_cnt    = r_cnt + CW'(1);
                    if (!w_empty) begin
                        n_cur  = w_back;
                        n_live = 1'b1;
                    end
                end
            end
            FN_POP_FRONT: begin
                if (!w_empty) begin
                    w_ctl.rd  = 1'b1;
                    w_ctl.shl = w_accept;
                    w_rd_pos  = '0;
                    w_dvalid  = 1'b1;
                    n_cnt     = r_cnt - CW'(1);
                    n_cur     = '0;
                    n_live    = (r_cnt != CW'(1));
                end
            end
            FN_POP_BACK: begin
                if (!w_empty) begin
                    w_ctl.rd = 1'b1;
                    w_rd_pos = w_back;
                    w_dvalid = 1'b1;
                    n_cnt    = r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        n_live = 1'b0;
                    end else begin
                        n_cur  = w_back - IW'(1);
                        n_live = 1'b1;
                    end
                end
            end
            FN_CUR_FRONT: begin
                n_cur  = w_empty ? r_cur : '0;
                n_live = !w_empty;
            end
            FN_CUR_BACK: begin
                n_cur  = w_empty ? r_cur : w_back;
                n_live = !w_empty;
            end
            FN_CUR_NEXT: begin
                if (r_live && !w_empty) begin
                    w_ctl.rd = 1'b1;
                    w_rd_pos = r_cur;
                    w_dvalid = 1'b1;
                    if (r_cur == w_back) begin
                        n_live = 1'b0;
                    end else begin
                        n_cur = r_cur + IW'(1);
                    end
                end else begin
                    n_live = 1'b0;
                end
            end
            FN_CUR_PREV: begin
                if (r_live && !w_empty) begin
                    w_ctl.rd = 1'b1;
                    w_rd_pos = r_cur;
                    w_dvalid = 1'b1;
                    if (r_cur == '0) begin
                        n_live = 1'b0;
                    end else begin
                        n_cur = r_cur - IW'(1);
                    end
                end else begin
                    n_live = 1'b0;
                end
            end
            FN_CLEAR: begin
                n_cnt  = '0;
                n_cur  = '0;
                n_live = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // ---- control state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_cur  <= '0;
            r_live <= 1'b0;
        end else if (w_accept) begin
            r_cnt  <= n_cnt;
            r_cur  <= n_cur;
            r_live <= n_live;
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data_out   <= w_rd_data;
            r_data_valid <= w_dvalid;
            r_count      <= n_cnt;
            r_empty      <= (n_cnt == '0);
            r_full       <= (n_cnt == CW'(DEPTH));
            r_rej        <= w_rej;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_data_out    = r_data_out;
    assign o_data_valid  = r_data_valid;
    assign o_entry_count = r_count;
    assign o_is_empty    = r_empty;
    assign o_is_full     = r_full;
    assign o_rejected    = r_rej;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for deque_with_cursor. An in-bench model of the ring,
// the count and the cursor predicts one status beat per accepted operation.
// Every result beat is compared field by field against the oldest
// prediction. A short directed pass covers the empty queue, filling to full,
// a refused push, stepping off both ends and clear. Random segments then
// lean toward filling, draining, walking the cursor or a mix. Both channels
// idle at random, with some stretches running at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    import dqc_pkg::*;

    localparam int DEPTH          = 16;
    localparam int DATA_W         = 32;
    localparam int IDX_W          = $clog2(DEPTH);
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int WATCHDOG_LIMIT = 500;

    // codes past the last operation are no-ops that return status only
    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 4'd9;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 4'd15;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              data_valid;
        logic [CNT_W-1:0]  count;
        logic              empty;
        logic              full;
        logic              rejected;
    } t_deque_status;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [FUNC_W-1:0]  i_func;
    logic [DATA_W-1:0]  i_data_in;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [DATA_W-1:0]  o_data_out;
    logic               o_data_valid;
    logic [CNT_W-1:0]   o_entry_count;
    logic               o_is_empty;
    logic               o_is_full;
    logic               o_rejected;

    // shadow of the deque
    logic [DATA_W-1:0]  ring_word [DEPTH];
    logic [IDX_W-1:0]   front_slot = '0;
    logic [CNT_W-1:0]   fill_cnt   = '0;
    logic [IDX_W-1:0]   cur_slot   = '0;
    logic               cur_live   = 1'b0;

    t_deque_status      pending_results [$];
    int                 err_cnt        = 0;
    int                 idle_cycles    = 0;
    int                 src_gap_max    = 7;
    int                 sink_stall_max = 7;
    int                 sink_wait      = 0;

    deque_with_cursor #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_data_in     (i_data_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_data_out    (o_data_out),
        .o_data_valid  (o_data_valid),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty),
        .o_is_full     (o_is_full),
        .o_rejected    (o_rejected)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [IDX_W-1:0] back_slot();
        return front_slot + IDX_W'(fill_cnt - 1'b1);
    endfunction

    // Apply one operation to the shadow deque and return its status beat.
    function automatic t_deque_status deque_apply(logic [FUNC_W-1:0] code,
                                                  logic [DATA_W-1:0] word);
        t_deque_status r;
        logic [IDX_W-1:0] s;
        r = '0;
        case (code)
            FN_PUSH_FRONT, FN_PUSH_BACK: begin
                if (fill_cnt == DEPTH) begin
                    r.rejected = 1'b1;
                end else if (fill_cnt == 0) begin
                    ring_word[front_slot] = word;
                    fill_cnt = CNT_W'(1);
                end else if (code == FN_PUSH_FRONT) begin
                    cur_slot = front_slot;
                    cur_live = 1'b1;
                    front_slot = front_slot - 1'b1;
                    ring_word[front_slot] = word;
                    fill_cnt = fill_cnt + 1'b1;
                end else begin
                    cur_slot = back_slot();
                    cur_live = 1'b1;
                    ring_word[front_slot + IDX_W'(fill_cnt)] = word;
                    fill_cnt = fill_cnt + 1'b1;
                end
            end
            FN_POP_FRONT, FN_POP_BACK: begin
                if (fill_cnt != 0) begin
                    s = (code == FN_POP_FRONT) ? front_slot : back_slot();
                    r.data = ring_word[s];
                    r.data_valid = 1'b1;
                    fill_cnt = fill_cnt - 1'b1;
                    if (fill_cnt == 0) begin
                        cur_live = 1'b0;
                    end else begin
                        if (code == FN_POP_FRONT)
                            front_slot = front_slot + 1'b1;
                        cur_slot = (code == FN_POP_FRONT) ? front_slot : back_slot();
                        cur_live = 1'b1;
                    end
                end
            end
            FN_CUR_FRONT, FN_CUR_BACK: begin
                if (fill_cnt == 0) begin
                    cur_live = 1'b0;
                end else begin
                    cur_slot = (code == FN_CUR_FRONT) ? front_slot : back_slot();
                    cur_live = 1'b1;
                end
            end
            FN_CUR_NEXT, FN_CUR_PREV: begin
                if (cur_live && fill_cnt != 0) begin
                    r.data = ring_word[cur_slot];
                    r.data_valid = 1'b1;
                    // stepping past either end drops the cursor
                    if (code == FN_CUR_NEXT) begin
                        if (cur_slot == back_slot())
                            cur_live = 1'b0;
                        else
                            cur_slot = cur_slot + 1'b1;
                    end else begin
                        if (cur_slot == front_slot)
                            cur_live = 1'b0;
                        else
                            cur_slot = cur_slot - 1'b1;
                    end
                end else begin
                    cur_live = 1'b0;
                end
            end
            FN_CLEAR: begin
                front_slot = '0;
                fill_cnt   = '0;
                cur_slot   = '0;
                cur_live   = 1'b0;
            end
            default: ;
        endcase
        r.count = fill_cnt;
        r.empty = (fill_cnt == 0);
        r.full  = (fill_cnt == DEPTH);
        return r;
    endfunction

    task automatic check_field(string name, logic [DATA_W-1:0] want,
                               logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Drive one operation beat and hold it until it is accepted.
    task automatic send_op(logic [FUNC_W-1:0] code, logic [DATA_W-1:0] word);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= code;
        i_data_in  <= word;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic test_empty_queue();
        send_op(FN_POP_FRONT, $urandom);
        send_op(FN_POP_BACK, $urandom);
        send_op(FN_CUR_FRONT, '0);
        send_op(FN_CUR_NEXT, '1);
    endtask

    task automatic test_fill_to_full();
        logic [DATA_W-1:0] word;
        for (int k = 0; k < DEPTH; k++) begin
            word = (k == 0) ? '0 : (k == 1) ? '1 : DATA_W'($urandom);
            send_op(k[0] ? FN_PUSH_BACK : FN_PUSH_FRONT, word);
        end
        send_op(FN_PUSH_BACK, 32'hDEAD_BEEF);
    endtask

    task automatic test_cursor_ends();
        send_op(FN_CUR_BACK, '0);
        send_op(FN_CUR_NEXT, '0);
        send_op(FN_CUR_PREV, '0);
        send_op(FN_CUR_FRONT, '0);
        send_op(FN_CUR_PREV, '0);
        send_op(FN_CLEAR, '1);
    endtask

    // Segments lean toward fill, drain, cursor walks or a balanced mix.
    task automatic test_random_ops(int n_items);
        int mode, seg_left, pick, push_w, pop_w;
        logic [FUNC_W-1:0] code;
        logic [DATA_W-1:0] word;
        seg_left = 0;
        mode = 0;
        for (int i = 0; i < n_items; i++) begin
            if (seg_left == 0) begin
                mode     = $urandom_range(0, 3);
                seg_left = $urandom_range(20, 80);
                src_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 7;
                sink_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
            end
            seg_left--;
            case (mode)
                0:       begin push_w = 60; pop_w = 15; end
                1:       begin push_w = 15; pop_w = 60; end
                2:       begin push_w = 20; pop_w = 10; end
                default: begin push_w = 35; pop_w = 30; end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 1)
                code = FN_CLEAR;
            else if (pick < 3)
                code = FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
            else if (pick < 3 + push_w)
                code = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
            else if (pick < 3 + push_w + pop_w)
                code = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
            else if ($urandom_range(0, 3) == 0)
                code = $urandom_range(0, 1) ? FN_CUR_BACK : FN_CUR_FRONT;
            else
                code = $urandom_range(0, 1) ? FN_CUR_PREV : FN_CUR_NEXT;
            case ($urandom_range(0, 15))
                0:       word = '0;
                1:       word = '1;
                default: word = DATA_W'($urandom);
            endcase
            send_op(code, word);
        end
    endtask

    // Result side: hold ready low for the drawn stall after each beat.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_wait > 0) begin
                i_out_ready <= 1'b0;
                sink_wait--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_deque_status want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sink_wait = $urandom_range(0, sink_stall_max);
                if (pending_results.size() == 0) begin
                    $error("result beat with no operation outstanding");
                    err_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("data_out", want.data, o_data_out);
                    check_field("data_valid", want.data_valid, o_data_valid);
                    check_field("entry_count", want.count, o_entry_count);
                    check_field("is_empty", want.empty, o_is_empty);
                    check_field("is_full", want.full, o_is_full);
                    check_field("rejected", want.rejected, o_rejected);
                end
            end
            if (i_in_valid && o_in_ready)
                pending_results.push_back(deque_apply(i_func, i_data_in));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("deque_with_cursor test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_func     = FN_CLEAR;
        i_data_in  = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_fill_to_full();
        test_cursor_ends();
        test_random_ops(1200);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        // catch any stray beat after the last expected one
        repeat (8) @(posedge i_clk);
        if (err_cnt == 0)
            $display("deque_with_cursor test passed");
        else
            $display("deque_with_cursor test failed");
        $finish;
    end

endmodule
